### design/ogru_pkg.sv
// Shared constants, types and helper functions of the occupancy grid ray update block.
`default_nettype none

package ogru_pkg;

  // Grid geometry
  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int ROW_W       = $clog2(GRID_HEIGHT);

  // Field widths
  localparam int COORD_W     = 16;
  localparam int ODDS_W      = 6;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int TOUCH_W     = 9;
  localparam int CLASS_W     = 2;
  localparam int DELTA_W     = 16;
  localparam int ERR_W       = 19;
  localparam int E2_W        = 20;
  localparam int SUM_W       = 8;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [COORD_W-1:0] GRID_WIDTH_C  = COORD_W'(GRID_WIDTH);
  localparam logic [COORD_W-1:0] GRID_HEIGHT_C = COORD_W'(GRID_HEIGHT);
  localparam logic [ADDR_W-1:0]  GRID_WIDTH_A  = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0]  GRID_LAST_A   = ADDR_W'(GRID_DEPTH - 1);
  localparam logic [TOUCH_W-1:0] TOUCH_MAX     = '1;

  // Register reset values, in tenths
  localparam logic [CFG_W-1:0] FREE_STEP_RST      = 5'd4;
  localparam logic [CFG_W-1:0] HIT_STEP_RST       = 5'd9;
  localparam logic [CFG_W-1:0] ODDS_LIMIT_RST     = 5'd20;
  localparam logic [CFG_W-1:0] OCCUPIED_LEVEL_RST = 5'd5;
  localparam logic [CFG_W-1:0] FREE_LEVEL_RST     = 5'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE_STEP      = 3'd0,
    CFG_HIT_STEP       = 3'd1,
    CFG_ODDS_LIMIT     = 3'd2,
    CFG_OCCUPIED_LEVEL = 3'd3,
    CFG_FREE_LEVEL     = 3'd4
  } cfg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_FREE     = 2'd0,
    CLASS_OCCUPIED = 2'd1,
    CLASS_UNKNOWN  = 2'd2
  } occ_class_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_RD_ISSUE,
    BK_RD_WAIT
  } back_state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [CFG_W-1:0] free_step;
    logic [CFG_W-1:0] hit_step;
    logic [CFG_W-1:0] odds_limit;
    logic [CFG_W-1:0] occupied_level;
    logic [CFG_W-1:0] free_level;
  } cfg_t;

  // Classified operation as it travels from front to back
  typedef struct packed {
    logic               is_read;
    coord_t             c0;
    coord_t             r0;
    coord_t             c1;
    coord_t             r1;
    logic               hit;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    logic               col_neg;
    logic               row_neg;
    logic               end_in;
  } op_t;

  typedef struct packed {
    occ_class_t                cls;
    logic signed [ODDS_W-1:0]  odds;
    logic [TOUCH_W-1:0]        touched;
    logic                      on_grid;
  } res_t;

  function automatic logic in_grid(input coord_t col, input coord_t row);
    logic [COORD_W-1:0] cu;
    logic [COORD_W-1:0] ru;
    cu = col;
    ru = row;
    return !cu[COORD_W-1] && !ru[COORD_W-1] && (cu < GRID_WIDTH_C) && (ru < GRID_HEIGHT_C);
  endfunction

  // Row-major cell address; only valid for in-grid coordinates
  function automatic logic [ADDR_W-1:0] cell_addr(input coord_t col, input coord_t row);
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] ca;
    ra = ADDR_W'(row[ROW_W-1:0]);
    ca = ADDR_W'(col[COL_W-1:0]);
    return ADDR_W'(ra * GRID_WIDTH_A) + ca;
  endfunction

endpackage

`default_nettype wire

### design/ogru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/ogru_front.sv
// Front end: accepts input transactions and classifies them into queue entries.
`default_nettype none

module ogru_front (
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ogru_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tuser,
  input  wire logic                              q_full,
  input  wire logic                              clearing,
  output logic                                   push,
  output ogru_pkg::op_t                          push_op
);
  import ogru_pkg::*;

  coord_t                    c0;
  coord_t                    r0;
  coord_t                    c1;
  coord_t                    r1;
  logic signed [COORD_W:0]   dc;
  logic signed [COORD_W:0]   dr;
  logic signed [COORD_W:0]   dc_abs;
  logic signed [COORD_W:0]   dr_abs;

  // Unpack the payload
  assign c0 = in_tdata[15:0];
  assign r0 = in_tdata[31:16];
  assign c1 = in_tdata[47:32];
  assign r1 = in_tdata[63:48];

  // Ray deltas and step directions
  always_comb begin
    dc     = (COORD_W+1)'(c1) - (COORD_W+1)'(c0);
    dr     = (COORD_W+1)'(r1) - (COORD_W+1)'(r0);
    dc_abs = dc[COORD_W] ? -dc : dc;
    dr_abs = dr[COORD_W] ? -dr : dr;
  end

  // Build the queue entry
  always_comb begin
    push_op.is_read = in_tuser;
    push_op.c0      = c0;
    push_op.r0      = r0;
    push_op.c1      = c1;
    push_op.r1      = r1;
    push_op.hit     = in_tdata[64];
    push_op.dx      = dc_abs[DELTA_W-1:0];
    push_op.dy      = dr_abs[DELTA_W-1:0];
    push_op.col_neg = !(c1 > c0);
    push_op.row_neg = !(r1 > r0);
    push_op.end_in  = in_grid(c1, r1);
  end

  // Hold off while the queue is full or the grid is being cleared
  assign in_tready = !q_full && !clearing;
  assign push      = in_tvalid && in_tready;

endmodule

`default_nettype wire

### design/ogru_queue.sv
// Short FIFO of classified operations between front and back.
`default_nettype none

module ogru_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ogru_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output ogru_pkg::op_t      pop_op,
  output logic               empty
);
  import ogru_pkg::*;

  op_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = entry_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

### design/ogru_back.sv
// Back end: clears the grid, walks rays with read-modify-write, serves reads, holds the result.
`default_nettype none

module ogru_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ogru_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire ogru_pkg::op_t   q_op,
  output logic                 pop,
  output logic                 clearing,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output ogru_pkg::res_t       out_res
);
  import ogru_pkg::*;

  back_state_t               state_r;
  back_state_t               state_nxt;

  // Walker state
  coord_t                    c_r;
  coord_t                    c_nxt;
  coord_t                    r_r;
  coord_t                    r_nxt;
  coord_t                    c1_r;
  coord_t                    c1_nxt;
  coord_t                    r1_r;
  coord_t                    r1_nxt;
  logic [DELTA_W-1:0]        dx_r;
  logic [DELTA_W-1:0]        dx_nxt;
  logic [DELTA_W-1:0]        dy_r;
  logic [DELTA_W-1:0]        dy_nxt;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   err_nxt;
  logic                      col_neg_r;
  logic                      col_neg_nxt;
  logic                      row_neg_r;
  logic                      row_neg_nxt;
  logic                      hit_r;
  logic                      hit_nxt;
  logic                      end_in_r;
  logic                      end_in_nxt;
  logic [TOUCH_W-1:0]        touched_r;
  logic [TOUCH_W-1:0]        touched_nxt;

  // Write-back stage
  logic                      st_vld_r;
  logic                      st_vld_nxt;
  logic [ADDR_W-1:0]         st_addr_r;
  logic [ADDR_W-1:0]         st_addr_nxt;
  logic                      st_end_r;
  logic                      st_end_nxt;

  logic [ADDR_W-1:0]         clr_addr_r;
  logic [ADDR_W-1:0]         clr_addr_nxt;

  logic                      out_vld_r;
  logic                      out_vld_nxt;
  res_t                      out_res_r;
  res_t                      out_res_nxt;

  // RAM ports
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ODDS_W-1:0]         ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ODDS_W-1:0]         ram_rdata;

  // Per-cycle helpers
  logic                      cur_in;
  logic                      at_end;
  logic                      out_free;
  logic                      out_load;
  logic signed [E2_W-1:0]    e2;
  logic signed [E2_W-1:0]    dx_e;
  logic signed [E2_W-1:0]    dy_e;
  logic                      step_col;
  logic                      step_row;
  logic signed [SUM_W-1:0]   cur_v;
  logic signed [SUM_W-1:0]   sum_v;
  logic signed [SUM_W-1:0]   lim_v;
  logic signed [SUM_W-1:0]   clamp_v;
  logic signed [SUM_W-1:0]   occ_v;
  logic signed [SUM_W-1:0]   free_v;
  occ_class_t                rd_cls;

  ogru_ram #(
    .WIDTH (ODDS_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_in   = in_grid(c_r, r_r);
  assign at_end   = (c_r == c1_r) && (r_r == r1_r);
  assign out_free = !out_vld_r || out_tready;

  // Bresenham step decision
  always_comb begin
    e2       = {err_r, 1'b0};
    dx_e     = $signed({4'b0, dx_r});
    dy_e     = $signed({4'b0, dy_r});
    step_col = (e2 > -dy_e);
    step_row = (e2 < dx_e);
  end

  // Update the cell coming back from the RAM and clamp it
  always_comb begin
    cur_v = SUM_W'($signed(ram_rdata));
    lim_v = $signed({3'b0, cfg.odds_limit});
    sum_v = cur_v;
    if (!st_end_r) begin
      sum_v = cur_v - $signed({3'b0, cfg.free_step});
    end else if (hit_r) begin
      sum_v = cur_v + $signed({3'b0, cfg.hit_step});
    end
    if (sum_v > lim_v) begin
      clamp_v = lim_v;
    end else if (sum_v < -lim_v) begin
      clamp_v = -lim_v;
    end else begin
      clamp_v = sum_v;
    end
  end

  // Classify the cell of a read
  always_comb begin
    occ_v  = $signed({3'b0, cfg.occupied_level});
    free_v = $signed({3'b0, cfg.free_level});
    if (cur_v > occ_v) begin
      rd_cls = CLASS_OCCUPIED;
    end else if (cur_v < -free_v) begin
      rd_cls = CLASS_FREE;
    end else begin
      rd_cls = CLASS_UNKNOWN;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == GRID_LAST_A) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_op.is_read ? BK_RD_ISSUE : BK_WALK;
        end
      end
      BK_WALK: begin
        if (at_end) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_RD_ISSUE: begin
        state_nxt = BK_RD_WAIT;
      end
      BK_RD_WAIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    pop       = 1'b0;
    clearing  = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    ram_we    = st_vld_r;
    ram_waddr = st_addr_r;
    ram_wdata = clamp_v[ODDS_W-1:0];
    ram_raddr = cell_addr(c_r, r_r);
    case (state_r)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        pop = !q_empty;
      end
      BK_WALK: begin
        ram_re = cur_in;
      end
      BK_DRAIN: begin
        out_load = out_free;
      end
      BK_RD_ISSUE: begin
        ram_re = cur_in;
      end
      BK_RD_WAIT: begin
        out_load = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Walker, write-back stage and result register
  always_comb begin
    c_nxt        = c_r;
    r_nxt        = r_r;
    c1_nxt       = c1_r;
    r1_nxt       = r1_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    err_nxt      = err_r;
    col_neg_nxt  = col_neg_r;
    row_neg_nxt  = row_neg_r;
    hit_nxt      = hit_r;
    end_in_nxt   = end_in_r;
    touched_nxt  = touched_r;
    st_vld_nxt   = 1'b0;
    st_addr_nxt  = ram_raddr;
    st_end_nxt   = at_end;
    clr_addr_nxt = clr_addr_r;
    out_res_nxt  = out_res_r;

    if (state_r == BK_CLEAR) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end

    // Load a new operation
    if (pop) begin
      c_nxt       = q_op.c0;
      r_nxt       = q_op.r0;
      c1_nxt      = q_op.c1;
      r1_nxt      = q_op.r1;
      dx_nxt      = q_op.dx;
      dy_nxt      = q_op.dy;
      err_nxt     = $signed({3'b0, q_op.dx}) - $signed({3'b0, q_op.dy});
      col_neg_nxt = q_op.col_neg;
      row_neg_nxt = q_op.row_neg;
      hit_nxt     = q_op.hit;
      end_in_nxt  = q_op.end_in;
      touched_nxt = '0;
    end

    // Issue the current cell and step along the line
    if (state_r == BK_WALK) begin
      st_vld_nxt = cur_in;
      if (cur_in && (touched_r != TOUCH_MAX)) begin
        touched_nxt = touched_r + 1'b1;
      end
      if (!at_end) begin
        if (step_col) begin
          c_nxt = c_r + (col_neg_r ? coord_t'(-1) : coord_t'(1));
        end
        if (step_row) begin
          r_nxt = r_r + (row_neg_r ? coord_t'(-1) : coord_t'(1));
        end
        err_nxt = err_r - (step_col ? ERR_W'(dy_r) : ERR_W'(0))
                        + (step_row ? ERR_W'(dx_r) : ERR_W'(0));
      end
    end

    // Capture the result
    if (out_load) begin
      if (state_r == BK_RD_WAIT) begin
        out_res_nxt.touched = '0;
        if (cur_in) begin
          out_res_nxt.cls     = rd_cls;
          out_res_nxt.odds    = cur_v[ODDS_W-1:0];
          out_res_nxt.on_grid = 1'b1;
        end else begin
          out_res_nxt.cls     = CLASS_UNKNOWN;
          out_res_nxt.odds    = '0;
          out_res_nxt.on_grid = 1'b0;
        end
      end else begin
        out_res_nxt.cls     = CLASS_FREE;
        out_res_nxt.odds    = '0;
        out_res_nxt.touched = touched_r;
        out_res_nxt.on_grid = end_in_r;
      end
    end

    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
      st_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      st_vld_r   <= st_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    r_r       <= r_nxt;
    c1_r      <= c1_nxt;
    r1_r      <= r1_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    err_r     <= err_nxt;
    col_neg_r <= col_neg_nxt;
    row_neg_r <= row_neg_nxt;
    hit_r     <= hit_nxt;
    end_in_r  <= end_in_nxt;
    touched_r <= touched_nxt;
    st_addr_r <= st_addr_nxt;
    st_end_r  <= st_end_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_res    = out_res_r;

endmodule

`default_nettype wire

### design/occupancy_grid_ray_update_top.sv
// Top level of the occupancy grid ray update block: register file, front, queue and back.
//
//   Group  Direction  Handshake            Contents
//   in_    slave      tvalid/tready        ray or cell read request
//   out_   master     tvalid/tready        class, log-odds, cells touched, inside flag
//   cfg_   write      we                   step, limit and level registers
//
// A ray walks max(|dx|,|dy|)+1 cells.
// The rate is set by the single walker, which issues one grid read per in-grid cell and
// writes the updated cell back through the second RAM port in the following cycle.
// After reset the grid is swept to zero, one cell per cycle, over all GRID_WIDTH*GRID_HEIGHT
// cells (65536 by default); in_tready stays low until the sweep is done.
// A two-entry queue lets the input side keep accepting while the walker works,
// and the result register lets the walker finish while out_tready is low.
`default_nettype none

module occupancy_grid_ray_update_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [15:0] start_col, [31:16] start_row, [47:32] end_col, [63:48] end_row, [64] hit
  input  wire logic [ogru_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] action
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [1:0] occupancy_class, [7:2] cell_odds, [16:8] cells_touched, [17] inside_grid
  output logic      [ogru_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [ogru_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ogru_pkg::CFG_W-1:0]           cfg_wdata
);
  import ogru_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  logic  clearing;
  op_t   push_op;
  op_t   pop_op;
  res_t  out_res;

  // Register writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FREE_STEP:      cfg_nxt.free_step      = cfg_wdata;
        CFG_HIT_STEP:       cfg_nxt.hit_step       = cfg_wdata;
        CFG_ODDS_LIMIT:     cfg_nxt.odds_limit     = cfg_wdata;
        CFG_OCCUPIED_LEVEL: cfg_nxt.occupied_level = cfg_wdata;
        CFG_FREE_LEVEL:     cfg_nxt.free_level     = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.free_step      <= FREE_STEP_RST;
      cfg_r.hit_step       <= HIT_STEP_RST;
      cfg_r.odds_limit     <= ODDS_LIMIT_RST;
      cfg_r.occupied_level <= OCCUPIED_LEVEL_RST;
      cfg_r.free_level     <= FREE_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ogru_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_op   (push_op)
  );

  ogru_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  ogru_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_op       (pop_op),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result transaction
  assign out_tdata = {6'b0, out_res.on_grid, out_res.touched, out_res.odds, out_res.cls};

endmodule

`default_nettype wire
